// ===== sv/outline_segment_to_tangent_points_core_assert.svh =====
// assertion macros for the outline tangent point core
// expects signals named clock and reset in the module that uses them
`ifndef OUTLINE_SEGMENT_TO_TANGENT_POINTS_CORE_ASSERT_SVH
`define OUTLINE_SEGMENT_TO_TANGENT_POINTS_CORE_ASSERT_SVH

// same-cycle implication
`define OS2TP_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define OS2TP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/os2tp_pkg.sv =====
// os2tp_pkg: widths, codes and shared types of the outline tangent point core
// no dependencies
`default_nettype none

package os2tp_pkg;

   localparam int COORD_WIDTH    = 24;
   localparam int SCALE_WIDTH    = 24;
   localparam int POS_WIDTH      = 32;
   localparam int DIFF_WIDTH     = POS_WIDTH + 1;
   localparam int FRAC_SHIFT     = 16;
   localparam int PROD_WIDTH     = COORD_WIDTH + SCALE_WIDTH + 1;
   localparam int SHIFT_WIDTH    = PROD_WIDTH - FRAC_SHIFT;
   localparam int EXT_WIDTH      = (SHIFT_WIDTH > DIFF_WIDTH) ? SHIFT_WIDTH : DIFF_WIDTH;
   localparam int ACTION_WIDTH   = 3;
   localparam int NUM_COORDS     = 6;
   localparam int REQ_DATA_WIDTH = ((NUM_COORDS * COORD_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_WIDTH = 6 * POS_WIDTH;
   localparam int RSP_USER_WIDTH = 3;
   localparam int COUNT_WIDTH    = 2;

   localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = SCALE_WIDTH'(65536);

   localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
   localparam logic signed [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

   // divide by three: split the offset numerator into two digits of SPLIT bits
   localparam int M_WIDTH     = DIFF_WIDTH + 1;
   localparam int SPLIT       = 17;
   localparam int HI_WIDTH    = M_WIDTH - SPLIT;
   localparam int QH_WIDTH    = POS_WIDTH - SPLIT;
   localparam int REM_WIDTH   = 2;
   localparam int X_WIDTH     = SPLIT + REM_WIDTH;
   localparam int RECIP_WIDTH = 19;
   localparam int RECIP_SHIFT = 20;
   localparam logic [RECIP_WIDTH-1:0] RECIP3 = RECIP_WIDTH'(((64'd1 << RECIP_SHIFT) + 2) / 3);
   localparam logic [M_WIDTH-1:0] M_OFFSET = M_WIDTH'(64'd3 << (POS_WIDTH - 1));
   localparam logic signed [DIFF_WIDTH-1:0] TAN_LIMIT =
      DIFF_WIDTH'(64'd3 << (POS_WIDTH - 2));

   typedef enum logic [ACTION_WIDTH-1:0] {
      ACT_MOVE  = 3'd0,
      ACT_LINE  = 3'd1,
      ACT_QUAD  = 3'd2,
      ACT_CUBIC = 3'd3,
      ACT_END   = 3'd4
   } action_type;

   typedef struct packed {
      logic signed [DIFF_WIDTH-1:0] d;
      logic                         third;
   } tan_raw_type;

   localparam tan_raw_type TAN_ZERO = '0;

   typedef struct packed {
      logic a;
      logic b;
   } stage_en_type;

   typedef struct packed {
      logic path_last;
      logic path_closed;
      logic outline_last;
      logic seg_error;
   } flags_type;

   typedef struct packed {
      logic signed [POS_WIDTH-1:0] pos_x;
      logic signed [POS_WIDTH-1:0] pos_y;
      tan_raw_type                 tin_x;
      tan_raw_type                 tin_y;
      tan_raw_type                 tout_x;
      tan_raw_type                 tout_y;
      flags_type                   flags;
   } point_rec_type;

endpackage

`default_nettype wire

// ===== sv/outline_segment_to_tangent_points_core.sv =====
// outline_segment_to_tangent_points_core: outline commands to scaled path points with tangents
// a result is emitted when the command that flushes it reaches the path state stage
// throughput: one command per cycle unless rsp_tready stalls; depth set by the scale multipliers,
// the path state stage and the two-stage divide by three of the tangents
// reset: synchronous, clears all stage valids and path state, scale returns to 1.0
// depends on os2tp_pkg, os2tp_thirds and the assertion macro header
`default_nettype none

`include "outline_segment_to_tangent_points_core_assert.svh"

module outline_segment_to_tangent_points_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y
   input  logic [os2tp_pkg::REQ_DATA_WIDTH-1:0]     req_tdata,
   // action
   input  logic [os2tp_pkg::ACTION_WIDTH-1:0]       req_tuser,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // pos_x, pos_y, tan_in_x, tan_in_y, tan_out_x, tan_out_y
   output logic [os2tp_pkg::RSP_DATA_WIDTH-1:0]     rsp_tdata,
   // path_last
   output logic                                     rsp_tlast,
   // path_closed, outline_last, seg_error
   output logic [os2tp_pkg::RSP_USER_WIDTH-1:0]     rsp_tuser,
   input  logic                                     csr_wr_en,
   input  logic [os2tp_pkg::SCALE_WIDTH-1:0]        csr_wr_data
);
   import os2tp_pkg::*;

   function automatic logic signed [POS_WIDTH-1:0] sat_pos(
      input logic signed [EXT_WIDTH-1:0] v
   );
      logic signed [POS_WIDTH-1:0] r;
      if (v > EXT_WIDTH'(POS_MAX)) begin
         r = POS_MAX;
      end else if (v < EXT_WIDTH'(POS_MIN)) begin
         r = POS_MIN;
      end else begin
         r = v[POS_WIDTH-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [DIFF_WIDTH-1:0] pos_diff(
      input logic signed [POS_WIDTH-1:0] a,
      input logic signed [POS_WIDTH-1:0] b
   );
      return DIFF_WIDTH'(a) - DIFF_WIDTH'(b);
   endfunction

   logic [SCALE_WIDTH-1:0]        scale_ff;

   logic                          in_ready;
   logic                          prod_ready;
   logic                          scl_ready;
   logic                          rec_ready;
   logic                          div_ready;
   logic                          rsp_ready;

   logic                          in_valid_ff;
   logic                          prod_valid_ff;
   logic                          scl_valid_ff;
   logic                          rec_valid_ff;
   logic                          div_valid_ff;
   logic                          rsp_valid_ff;

   action_type                    in_act_ff;
   action_type                    prod_act_ff;
   action_type                    scl_act_ff;
   logic signed [COORD_WIDTH-1:0] in_coord_ff [NUM_COORDS];
   logic signed [PROD_WIDTH-1:0]  prod_in     [NUM_COORDS];
   logic signed [PROD_WIDTH-1:0]  prod_ff     [NUM_COORDS];
   logic signed [POS_WIDTH-1:0]   scl_in      [NUM_COORDS];
   logic signed [POS_WIDTH-1:0]   scl_ff      [NUM_COORDS];

   logic signed [POS_WIDTH-1:0]   pend_x_in;
   logic signed [POS_WIDTH-1:0]   pend_x_ff;
   logic signed [POS_WIDTH-1:0]   pend_y_in;
   logic signed [POS_WIDTH-1:0]   pend_y_ff;
   tan_raw_type                   pend_tin_x_in;
   tan_raw_type                   pend_tin_x_ff;
   tan_raw_type                   pend_tin_y_in;
   tan_raw_type                   pend_tin_y_ff;
   logic                          pend_valid_in;
   logic                          pend_valid_ff;
   logic                          path_open_in;
   logic                          path_open_ff;
   logic [COUNT_WIDTH-1:0]        path_count_in;
   logic [COUNT_WIDTH-1:0]        path_count_ff;
   logic                          aborted_in;
   logic                          aborted_ff;

   logic                          step;
   logic                          emit;
   tan_raw_type                   seg_tin_x;
   tan_raw_type                   seg_tin_y;
   tan_raw_type                   seg_tout_x;
   tan_raw_type                   seg_tout_y;
   point_rec_type                 rec_in;
   point_rec_type                 rec_ff;

   logic signed [POS_WIDTH-1:0]   div_pos_x_ff;
   logic signed [POS_WIDTH-1:0]   div_pos_y_ff;
   flags_type                     div_flags_ff;
   logic signed [POS_WIDTH-1:0]   rsp_pos_x_ff;
   logic signed [POS_WIDTH-1:0]   rsp_pos_y_ff;
   flags_type                     rsp_flags_ff;
   logic signed [POS_WIDTH-1:0]   tin_x_q;
   logic signed [POS_WIDTH-1:0]   tin_y_q;
   logic signed [POS_WIDTH-1:0]   tout_x_q;
   logic signed [POS_WIDTH-1:0]   tout_y_q;
   stage_en_type                  div_en;

   // scale register
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_wr_en) begin
         scale_ff <= csr_wr_data;
      end
   end

   // stage handshake, a stage loads when empty or draining
   assign rsp_ready  = !rsp_valid_ff || rsp_tready;
   assign div_ready  = !div_valid_ff || rsp_ready;
   assign rec_ready  = !rec_valid_ff || div_ready;
   assign scl_ready  = !scl_valid_ff || rec_ready;
   assign prod_ready = !prod_valid_ff || scl_ready;
   assign in_ready   = !in_valid_ff || prod_ready;
   assign req_tready = in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         scl_valid_ff  <= 1'b0;
         rec_valid_ff  <= 1'b0;
         div_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (in_ready) begin
            in_valid_ff <= req_tvalid;
         end
         if (prod_ready) begin
            prod_valid_ff <= in_valid_ff;
         end
         if (scl_ready) begin
            scl_valid_ff <= prod_valid_ff;
         end
         if (rec_ready) begin
            rec_valid_ff <= scl_valid_ff && emit;
         end
         if (div_ready) begin
            div_valid_ff <= rec_valid_ff;
         end
         if (rsp_ready) begin
            rsp_valid_ff <= div_valid_ff;
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (in_ready) begin
         in_act_ff <= action_type'(req_tuser);
         for (int i = 0; i < NUM_COORDS; i++) begin
            in_coord_ff[i] <= req_tdata[i*COORD_WIDTH +: COORD_WIDTH];
         end
      end
   end

   // scale products
   always_comb begin
      for (int i = 0; i < NUM_COORDS; i++) begin
         prod_in[i] = PROD_WIDTH'(in_coord_ff[i]) * PROD_WIDTH'($signed({1'b0, scale_ff}));
      end
   end

   always_ff @(posedge clock) begin
      if (prod_ready) begin
         prod_act_ff <= in_act_ff;
         for (int i = 0; i < NUM_COORDS; i++) begin
            prod_ff[i] <= prod_in[i];
         end
      end
   end

   // floor shift and saturate, y coordinates negated
   always_comb begin
      logic signed [PROD_WIDTH-1:0] p;
      for (int i = 0; i < NUM_COORDS; i++) begin
         p = ((i % 2) == 1) ? -prod_ff[i] : prod_ff[i];
         scl_in[i] = sat_pos(EXT_WIDTH'($signed(p[PROD_WIDTH-1:FRAC_SHIFT])));
      end
   end

   always_ff @(posedge clock) begin
      if (scl_ready) begin
         scl_act_ff <= prod_act_ff;
         for (int i = 0; i < NUM_COORDS; i++) begin
            scl_ff[i] <= scl_in[i];
         end
      end
   end

   // tangents of the incoming segment
   always_comb begin
      seg_tin_x  = TAN_ZERO;
      seg_tin_y  = TAN_ZERO;
      seg_tout_x = TAN_ZERO;
      seg_tout_y = TAN_ZERO;
      case (scl_act_ff)
         ACT_QUAD: begin
            seg_tout_x = '{d: pos_diff(scl_ff[0], pend_x_ff), third: 1'b1};
            seg_tout_y = '{d: pos_diff(scl_ff[1], pend_y_ff), third: 1'b1};
            seg_tin_x  = '{d: pos_diff(scl_ff[0], scl_ff[4]), third: 1'b1};
            seg_tin_y  = '{d: pos_diff(scl_ff[1], scl_ff[5]), third: 1'b1};
         end
         ACT_CUBIC: begin
            seg_tout_x = '{d: pos_diff(scl_ff[0], pend_x_ff), third: 1'b0};
            seg_tout_y = '{d: pos_diff(scl_ff[1], pend_y_ff), third: 1'b0};
            seg_tin_x  = '{d: pos_diff(scl_ff[2], scl_ff[4]), third: 1'b0};
            seg_tin_y  = '{d: pos_diff(scl_ff[3], scl_ff[5]), third: 1'b0};
         end
         default: begin
         end
      endcase
   end

   // path state and point emission
   assign step = scl_valid_ff && rec_ready;

   always_comb begin
      pend_x_in     = pend_x_ff;
      pend_y_in     = pend_y_ff;
      pend_tin_x_in = pend_tin_x_ff;
      pend_tin_y_in = pend_tin_y_ff;
      pend_valid_in = pend_valid_ff;
      path_open_in  = path_open_ff;
      path_count_in = path_count_ff;
      aborted_in    = aborted_ff;
      emit          = 1'b0;
      rec_in        = '0;
      rec_in.pos_x  = pend_x_ff;
      rec_in.pos_y  = pend_y_ff;
      rec_in.tin_x  = pend_tin_x_ff;
      rec_in.tin_y  = pend_tin_y_ff;
      if (step) begin
         case (scl_act_ff)
            ACT_END: begin
               if (!aborted_ff && pend_valid_ff) begin
                  emit                     = 1'b1;
                  rec_in.flags.path_last    = 1'b1;
                  rec_in.flags.path_closed  = path_count_ff[1];
                  rec_in.flags.outline_last = 1'b1;
               end
               pend_valid_in = 1'b0;
               path_open_in  = 1'b0;
               path_count_in = '0;
               aborted_in    = 1'b0;
            end
            ACT_MOVE: begin
               if (!aborted_ff) begin
                  if (pend_valid_ff) begin
                     emit                    = 1'b1;
                     rec_in.flags.path_last   = 1'b1;
                     rec_in.flags.path_closed = path_count_ff[1];
                  end
                  pend_x_in     = scl_ff[4];
                  pend_y_in     = scl_ff[5];
                  pend_tin_x_in = TAN_ZERO;
                  pend_tin_y_in = TAN_ZERO;
                  pend_valid_in = 1'b1;
                  path_open_in  = 1'b1;
                  path_count_in = COUNT_WIDTH'(1);
               end
            end
            ACT_LINE, ACT_QUAD, ACT_CUBIC: begin
               if (!aborted_ff) begin
                  emit = 1'b1;
                  if (!path_open_ff || !pend_valid_ff) begin
                     rec_in                 = '0;
                     rec_in.flags.seg_error = 1'b1;
                     aborted_in             = 1'b1;
                  end else begin
                     rec_in.tout_x = seg_tout_x;
                     rec_in.tout_y = seg_tout_y;
                     pend_x_in     = scl_ff[4];
                     pend_y_in     = scl_ff[5];
                     pend_tin_x_in = seg_tin_x;
                     pend_tin_y_in = seg_tin_y;
                     if (!path_count_ff[1]) begin
                        path_count_in = path_count_ff + COUNT_WIDTH'(1);
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         path_open_ff  <= 1'b0;
         path_count_ff <= '0;
         aborted_ff    <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         path_open_ff  <= path_open_in;
         path_count_ff <= path_count_in;
         aborted_ff    <= aborted_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_x_ff     <= pend_x_in;
      pend_y_ff     <= pend_y_in;
      pend_tin_x_ff <= pend_tin_x_in;
      pend_tin_y_ff <= pend_tin_y_in;
      if (rec_ready) begin
         rec_ff <= rec_in;
      end
   end

   // tangent finish, two stages alongside the point pass-through
   assign div_en = '{a: div_ready, b: rsp_ready};

   os2tp_thirds u_tin_x (
      .clock (clock),
      .en    (div_en),
      .tan   (rec_ff.tin_x),
      .tan_q (tin_x_q)
   );

   os2tp_thirds u_tin_y (
      .clock (clock),
      .en    (div_en),
      .tan   (rec_ff.tin_y),
      .tan_q (tin_y_q)
   );

   os2tp_thirds u_tout_x (
      .clock (clock),
      .en    (div_en),
      .tan   (rec_ff.tout_x),
      .tan_q (tout_x_q)
   );

   os2tp_thirds u_tout_y (
      .clock (clock),
      .en    (div_en),
      .tan   (rec_ff.tout_y),
      .tan_q (tout_y_q)
   );

   always_ff @(posedge clock) begin
      if (div_ready) begin
         div_pos_x_ff <= rec_ff.pos_x;
         div_pos_y_ff <= rec_ff.pos_y;
         div_flags_ff <= rec_ff.flags;
      end
      if (rsp_ready) begin
         rsp_pos_x_ff <= div_pos_x_ff;
         rsp_pos_y_ff <= div_pos_y_ff;
         rsp_flags_ff <= div_flags_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {tout_y_q, tout_x_q, tin_y_q, tin_x_q, rsp_pos_y_ff, rsp_pos_x_ff};
   assign rsp_tlast  = rsp_flags_ff.path_last;
   assign rsp_tuser  = {rsp_flags_ff.seg_error, rsp_flags_ff.outline_last,
                        rsp_flags_ff.path_closed};

   `OS2TP_ASSERT_IMPLY(a_error_clean, rsp_valid_ff && rsp_flags_ff.seg_error,
      rsp_tdata == '0 && !rsp_flags_ff.path_last && !rsp_flags_ff.path_closed
      && !rsp_flags_ff.outline_last, "error result carries data")
   `OS2TP_ASSERT_IMPLY(a_end_flags,
      rsp_valid_ff && (rsp_flags_ff.path_closed || rsp_flags_ff.outline_last),
      rsp_flags_ff.path_last, "closed or outline end without path end")
   `OS2TP_ASSERT_IMPLY(a_abort_empty, aborted_ff,
      !pend_valid_ff && !path_open_ff, "aborted with a pending point")
   `OS2TP_ASSERT_NEXT(a_end_clears, step && scl_act_ff == ACT_END,
      !pend_valid_ff && !aborted_ff && path_count_ff == '0, "end did not clear path state")

endmodule

`default_nettype wire

// ===== sv/os2tp_thirds.sv =====
// os2tp_thirds: two-stage tangent finish, saturated difference or rounded 2d/3
// depends on os2tp_pkg
`default_nettype none

module os2tp_thirds (
   input  logic                                   clock,
   input  os2tp_pkg::stage_en_type                en,
   input  os2tp_pkg::tan_raw_type                 tan,
   output logic signed [os2tp_pkg::POS_WIDTH-1:0] tan_q
);
   import os2tp_pkg::*;

   logic                          hi_sat;
   logic                          lo_sat;
   logic                          pass_hi;
   logic                          pass_lo;
   logic [M_WIDTH-1:0]            m_full;
   logic [HI_WIDTH+RECIP_WIDTH-1:0] prod_a;
   logic signed [POS_WIDTH-1:0]   fix_in;
   logic signed [POS_WIDTH-1:0]   fix_ff;
   logic                          use_div_in;
   logic                          use_div_ff;
   logic [HI_WIDTH-1:0]           mh_ff;
   logic [QH_WIDTH-1:0]           qh_ff;
   logic [SPLIT-1:0]              ml_ff;
   logic [HI_WIDTH-1:0]           rem_full;
   logic [X_WIDTH-1:0]            x_b;
   logic [X_WIDTH+RECIP_WIDTH-1:0] prod_b;
   logic [POS_WIDTH-1:0]          q_off;
   logic signed [POS_WIDTH-1:0]   tan_q_in;
   logic signed [POS_WIDTH-1:0]   tan_q_ff;

   // stage a: clamp, offset numerator 2d+1 to positive, high digit over three
   assign hi_sat  = tan.d >= TAN_LIMIT;
   assign lo_sat  = tan.d < -TAN_LIMIT;
   assign pass_hi = tan.d[DIFF_WIDTH-1:DIFF_WIDTH-2] == 2'b01;
   assign pass_lo = tan.d[DIFF_WIDTH-1:DIFF_WIDTH-2] == 2'b10;
   assign m_full  = {tan.d, 1'b1} + M_OFFSET;
   assign prod_a  = m_full[M_WIDTH-1:SPLIT] * RECIP3;

   always_comb begin
      use_div_in = 1'b0;
      fix_in     = tan.d[POS_WIDTH-1:0];
      if (tan.third) begin
         if (hi_sat) begin
            fix_in = POS_MAX;
         end else if (lo_sat) begin
            fix_in = POS_MIN;
         end else begin
            use_div_in = 1'b1;
         end
      end else if (pass_hi) begin
         fix_in = POS_MAX;
      end else if (pass_lo) begin
         fix_in = POS_MIN;
      end
   end

   always_ff @(posedge clock) begin
      if (en.a) begin
         fix_ff     <= fix_in;
         use_div_ff <= use_div_in;
         mh_ff      <= m_full[M_WIDTH-1:SPLIT];
         qh_ff      <= prod_a[RECIP_SHIFT+QH_WIDTH-1:RECIP_SHIFT];
         ml_ff      <= m_full[SPLIT-1:0];
      end
   end

   // stage b: remainder carried into the low digit, then remove the offset
   assign rem_full = mh_ff - ((HI_WIDTH'(qh_ff) << 1) + HI_WIDTH'(qh_ff));
   assign x_b      = {rem_full[REM_WIDTH-1:0], ml_ff};
   assign prod_b   = x_b * RECIP3;
   assign q_off    = {qh_ff, prod_b[RECIP_SHIFT+SPLIT-1:RECIP_SHIFT]};
   assign tan_q_in = use_div_ff ? {~q_off[POS_WIDTH-1], q_off[POS_WIDTH-2:0]} : fix_ff;

   always_ff @(posedge clock) begin
      if (en.b) begin
         tan_q_ff <= tan_q_in;
      end
   end

   assign tan_q = tan_q_ff;

endmodule

`default_nettype wire
